// ----- rtl/tcpq_pkg.sv -----
// shared constants, codes and command/status types of the three-class priority queue
package tcpq_pkg;

   localparam int CAPACITY    = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int NUM_CLASSES = 3;
   localparam int DEPTH       = NUM_CLASSES * CAPACITY;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int SUM_W       = CNT_W + 2;
   localparam int CLS_W       = 2;
   localparam int OUT_DATA_W  = 32;
   localparam int IN_DATA_W   = 32;
   localparam int OCC_W       = 5;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [CLS_W-1:0] {
      CLS_NORMAL  = 2'd0,
      CLS_HIGH    = 2'd1,
      CLS_SPECIAL = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      STAT_PUSHED = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_POPPED = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic       do_push;
      logic       do_pop;
      logic       load_now;
      logic       load_mem;
      status_type status;
   } tcpq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tcpq_stat_type;

   // flat slot address of one ring entry
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [IDX_W-1:0] slot);
      return ADDR_W'(cls) * ADDR_W'(CAPACITY) + ADDR_W'(slot);
   endfunction

endpackage

// ----- rtl/tcpq_ctrl.sv -----
// controller state machine of the three-class priority queue
module tcpq_ctrl
   import tcpq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [CLS_W-1:0]   req_priority_class,
   input  tcpq_stat_type      stat,
   output tcpq_cmd_type       cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      cls_ok;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      cls_ok    = req_priority_class inside {CLS_NORMAL, CLS_HIGH, CLS_SPECIAL};
      cmd       = '0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_POP) begin
                  if (stat.empty) begin
                     cmd.load_now = 1'b1;
                     cmd.status   = STAT_EMPTY;
                  end else begin
                     cmd.do_pop = 1'b1;
                     state_in   = S_READ;
                  end
               end else begin
                  cmd.load_now = 1'b1;
                  if (!cls_ok || stat.full) begin
                     cmd.status = STAT_FULL;
                  end else begin
                     cmd.do_push = 1'b1;
                     cmd.status  = STAT_PUSHED;
                  end
               end
            end
         end
         S_READ: begin
            cmd.load_mem = 1'b1;
            cmd.status   = STAT_POPPED;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.load_now || cmd.load_mem) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/tcpq_dp.sv -----
// datapath of the three-class priority queue: slot memory, ring pointers, counts, result register
module tcpq_dp
   import tcpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  tcpq_cmd_type          cmd,
   output tcpq_stat_type         stat,
   input  logic [CLS_W-1:0]      req_priority_class,
   input  logic [IN_DATA_W-1:0]  req_item_data,
   output logic [1:0]            rsp_status,
   output logic [OUT_DATA_W-1:0] rsp_popped_data,
   output logic [CLS_W-1:0]      rsp_popped_class,
   output logic [OCC_W-1:0]      rsp_occupancy
);

   logic [IDX_W-1:0]      rd_idx_ff [NUM_CLASSES];
   logic [IDX_W-1:0]      rd_idx_in [NUM_CLASSES];
   logic [CNT_W-1:0]      fill_ff   [NUM_CLASSES];
   logic [CNT_W-1:0]      fill_in   [NUM_CLASSES];
   logic [CNT_W-1:0]      total_ff, total_in;

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [CLS_W-1:0]      pop_cls_ff;

   status_type            status_ff;
   logic [OUT_DATA_W-1:0] pdata_ff;
   logic [CLS_W-1:0]      pclass_ff;
   logic [OCC_W-1:0]      occ_ff;

   logic [CLS_W-1:0]      pop_cls;
   logic [IDX_W:0]        wr_sum;
   logic [IDX_W-1:0]      wr_slot;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;

   always_comb begin
      stat.full  = total_ff >= CNT_W'(CAPACITY);
      stat.empty = total_ff == '0;

      // highest class that holds anything
      if (fill_ff[CLS_SPECIAL] != '0) begin
         pop_cls = CLS_SPECIAL;
      end else if (fill_ff[CLS_HIGH] != '0) begin
         pop_cls = CLS_HIGH;
      end else begin
         pop_cls = CLS_NORMAL;
      end
      rd_addr = slot_addr(pop_cls, rd_idx_ff[pop_cls]);

      // tail slot = (head + fill) wrapped once
      wr_sum  = (IDX_W+1)'(rd_idx_ff[req_priority_class])
              + (IDX_W+1)'(fill_ff[req_priority_class]);
      if (wr_sum >= (IDX_W+1)'(CAPACITY)) begin
         wr_slot = IDX_W'(wr_sum - (IDX_W+1)'(CAPACITY));
      end else begin
         wr_slot = IDX_W'(wr_sum);
      end
      wr_addr = slot_addr(req_priority_class, wr_slot);

      for (int c = 0; c < NUM_CLASSES; c++) begin
         rd_idx_in[c] = rd_idx_ff[c];
         fill_in[c]   = fill_ff[c];
      end
      total_in = total_ff;
      if (cmd.do_push) begin
         fill_in[req_priority_class] = fill_ff[req_priority_class] + 1'b1;
         total_in                    = total_ff + 1'b1;
      end else if (cmd.do_pop) begin
         if (rd_idx_ff[pop_cls] == IDX_W'(CAPACITY - 1)) begin
            rd_idx_in[pop_cls] = '0;
         end else begin
            rd_idx_in[pop_cls] = rd_idx_ff[pop_cls] + 1'b1;
         end
         fill_in[pop_cls] = fill_ff[pop_cls] - 1'b1;
         total_in         = total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_idx_ff[c] <= '0;
            fill_ff[c]   <= '0;
         end
         total_ff <= '0;
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_idx_ff[c] <= rd_idx_in[c];
            fill_ff[c]   <= fill_in[c];
         end
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         mem_ff[wr_addr] <= DATA_WIDTH'(req_item_data);
      end
      if (cmd.do_pop) begin
         rd_data_ff <= mem_ff[rd_addr];
         pop_cls_ff <= pop_cls;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_now) begin
         status_ff <= cmd.status;
         pdata_ff  <= '0;
         pclass_ff <= '0;
         occ_ff    <= OCC_W'(total_in);
      end else if (cmd.load_mem) begin
         status_ff <= cmd.status;
         pdata_ff  <= OUT_DATA_W'(rd_data_ff);
         pclass_ff <= pop_cls_ff;
         occ_ff    <= OCC_W'(total_ff);
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_popped_data  = pdata_ff;
   assign rsp_popped_class = pclass_ff;
   assign rsp_occupancy    = occ_ff;

   a_total_is_sum: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(total_ff) == SUM_W'(fill_ff[0]) + SUM_W'(fill_ff[1]) + SUM_W'(fill_ff[2]))
      else $error("total count differs from sum of class fills");

   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("total count above capacity");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> !stat.full && !cmd.do_pop)
      else $error("push committed while full or together with pop");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |-> !stat.empty)
      else $error("pop committed on empty store");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |=> total_ff == CNT_W'($past(total_ff) + 1'b1))
      else $error("push did not raise total count");

endmodule

// ----- rtl/three_class_priority_queue.sv -----
// top level of the three-class strict priority queue
//
// bounded store of 16 items shared by three classes (special, high, normal), each kept
// as its own fifo ring in one 48-entry slot memory with a registered read port. a push
// beat stores its word at the tail of its class ring and answers pushed, or answers full
// rejected when 16 items are held or the class code is 3; a pop beat answers with the
// oldest word of the highest non-empty class, or empty. every request beat gets exactly
// one response beat carrying the occupancy after the operation. pushes, rejected pushes
// and empty pops are answered in the cycle after the request; a successful pop first
// reads the slot memory into a register, then loads the response in the read state. one
// request is in flight at a time; the next request beat is taken as soon as the response
// register is empty or is being drained in the same cycle, so back-to-back pushes run at
// one beat per cycle while responses drain, and no beat is taken while a pop waits on its
// read. all memory contents are written before they are read, so the slot memory needs no clearing
module three_class_priority_queue
   import tcpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [CLS_W-1:0]      req_priority_class,
   input  logic [IN_DATA_W-1:0]  req_item_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [OUT_DATA_W-1:0] rsp_popped_data,
   output logic [CLS_W-1:0]      rsp_popped_class,
   output logic [OCC_W-1:0]      rsp_occupancy
);

   // commands from the state machine to the datapath
   tcpq_cmd_type  cmd;
   // full and empty flags back to the state machine
   tcpq_stat_type stat;

   // sequencing: accept, decide push/reject/pop, wait on memory read, load response
   tcpq_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_priority_class (req_priority_class),
      .stat               (stat),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready)
   );

   // storage, ring pointers, counts and the response payload register
   tcpq_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_priority_class (req_priority_class),
      .req_item_data      (req_item_data),
      .rsp_status         (rsp_status),
      .rsp_popped_data    (rsp_popped_data),
      .rsp_popped_class   (rsp_popped_class),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule
